// File: rtl/sha256_stream_hasher_assert.svh
// ----------------------------------------------------------------------------
// sha256_stream_hasher assertion macros
// Shared forms for the concurrent checks of the hasher.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// same-cycle implication
`define SHA_SH_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHA_SH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sha_sh_pkg.sv
// ----------------------------------------------------------------------------
// sha_sh_pkg
// Types, constants and round functions of the byte-serial SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_sh_pkg;

	localparam int unsigned ROUNDS = 64;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [2:0] WORD_LAST = 3'd7;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [63:0] BYTE_BITS = 64'd8;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// index 0 is working variable a (or H0)
	typedef logic [7:0][31:0] hash_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       ready;
		logic       byte_vld;
		logic [7:0] byte_val;
		logic       word_end;
		logic       load_work;
		logic       round_en;
		logic [5:0] rnd;
		logic       fold;
		logic       out_valid;
		logic [2:0] out_idx;
		logic       restart;
	} ctrl_t;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

// File: rtl/sha256_stream_hasher.sv
// Absorb: the byte that fills a block holds the input (item_stall) while the
// 64 rounds and the fold of that block run.
// Finish: padding bytes up to the block end, the rounds and fold of each padded
// block (one or two), then 8 digest words, one per cycle when not stalled.
// A single shared round unit and the 16-word schedule line serve all rounds.
// Reset: arst_n clears the sequencer and loads the initial hash; no clearing pass.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-serial SHA-256 hasher: absorbs message bytes, pads on finish and
// delivers the digest as eight big-endian 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire sha_sh_pkg::in_item_t item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output sha_sh_pkg::out_item_t     result
);
	import sha_sh_pkg::*;

	ctrl_t       ctrl;
	hash_t       h_q;
	hash_t       work_q;
	hash_t       work_nxt;
	logic [23:0] acc_q;
	logic [31:0] w_t;

	sha_sh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_op      (item.op),
		.item_byte    (item.data_byte),
		.result_stall (result_stall),
		.ctrl         (ctrl)
	);

	sha_sh_sched u_sched (
		.clk       (clk),
		.push      (ctrl.word_end),
		.push_word ({acc_q, ctrl.byte_val}),
		.shift     (ctrl.round_en),
		.w_t       (w_t)
	);

	sha_sh_round u_round (
		.cur (work_q),
		.k   (ROUND_K[ctrl.rnd]),
		.w   (w_t),
		.nxt (work_nxt)
	);

	// byte packer, big-endian
	always_ff @(posedge clk) begin
		if (ctrl.byte_vld) begin
			acc_q <= {acc_q[15:0], ctrl.byte_val};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_work) begin
			work_q <= h_q;
		end else if (ctrl.round_en) begin
			work_q <= work_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else if (ctrl.restart) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else if (ctrl.fold) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + work_q[i];
			end
		end
	end

	assign item_stall         = !ctrl.ready;
	assign result_valid       = ctrl.out_valid;
	assign result.digest_word = h_q[ctrl.out_idx];
	assign result.word_index  = ctrl.out_idx;
	assign result.last        = (ctrl.out_idx == WORD_LAST);

endmodule

`default_nettype wire

// File: rtl/sha_sh_sched.sv
// ----------------------------------------------------------------------------
// sha_sh_sched
// Sixteen-word message schedule shift line: filled with block words, then
// extended by one word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_sh_sched (
	input  wire logic        clk,
	input  wire logic        push,
	input  wire logic [31:0] push_word,
	input  wire logic        shift,
	output logic [31:0]      w_t
);
	import sha_sh_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] w_new;

	// W[t+16] = W[t] + s0(W[t+1]) + W[t+9] + s1(W[t+14])
	assign w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
	assign w_t = w_q[0];

	always_ff @(posedge clk) begin
		if (push || shift) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= push ? push_word : w_new;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sha_sh_round.sv
// ----------------------------------------------------------------------------
// sha_sh_round
// One SHA-256 compression round, reused for all 64 rounds of a block.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_sh_round (
	input  wire sha_sh_pkg::hash_t cur,
	input  wire logic [31:0]       k,
	input  wire logic [31:0]       w,
	output sha_sh_pkg::hash_t      nxt
);
	import sha_sh_pkg::*;

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		ch  = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
		maj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
		t1  = cur[7] + bsig1(cur[4]) + ch + k + w;
		t2  = bsig0(cur[0]) + maj;
		nxt[0] = t1 + t2;
		nxt[1] = cur[0];
		nxt[2] = cur[1];
		nxt[3] = cur[2];
		nxt[4] = cur[3] + t1;
		nxt[5] = cur[4];
		nxt[6] = cur[5];
		nxt[7] = cur[6];
	end

endmodule

`default_nettype wire

// File: rtl/sha_sh_ctrl.sv
// ----------------------------------------------------------------------------
// sha_sh_ctrl
// Sequencer: byte fill, padding bytes, round count, digest word count and
// the message bit counter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_assert.svh"

module sha_sh_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire logic        item_op,
	input  wire logic [7:0]  item_byte,
	input  wire logic        result_stall,
	output sha_sh_pkg::ctrl_t ctrl
);
	import sha_sh_pkg::*;

	state_t      state_q, state_d;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  out_idx_q;
	logic [63:0] bitcnt_q;
	logic [63:0] len_q;
	logic        fin_q;
	logic        pad_first_q;
	logic        len_ph_q;
	logic        done_q;

	logic absorb;
	logic finish;
	logic is_len;
	logic byte_vld;
	logic out_fire;
	logic out_last;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (finish) begin
					state_d = ST_PAD;
				end else if (absorb && fill_q == BLOCK_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_PAD: begin
				if (fill_q == BLOCK_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == BLOCK_LAST) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (done_q) begin
					state_d = ST_OUT;
				end else if (fin_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		absorb   = (state_q == ST_IDLE) && item_valid && !item_op;
		finish   = (state_q == ST_IDLE) && item_valid && item_op;
		// length bytes start at byte 56 of the final block
		is_len   = len_ph_q || (fill_q == LEN_POS && !pad_first_q);
		byte_vld = absorb || (state_q == ST_PAD);
		out_fire = (state_q == ST_OUT) && !result_stall;
		out_last = out_fire && (out_idx_q == WORD_LAST);

		ctrl.ready    = (state_q == ST_IDLE);
		ctrl.byte_vld = byte_vld;
		if (absorb) begin
			ctrl.byte_val = item_byte;
		end else if (pad_first_q) begin
			ctrl.byte_val = PAD_MARK;
		end else if (is_len) begin
			ctrl.byte_val = len_q[63:56];
		end else begin
			ctrl.byte_val = 8'h00;
		end
		ctrl.word_end  = byte_vld && (fill_q[1:0] == 2'b11);
		ctrl.load_work = byte_vld && (fill_q == BLOCK_LAST);
		ctrl.round_en  = (state_q == ST_ROUND);
		ctrl.rnd       = rnd_q;
		ctrl.fold      = (state_q == ST_FOLD);
		ctrl.out_valid = (state_q == ST_OUT);
		ctrl.out_idx   = out_idx_q;
		ctrl.restart   = out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rnd_q       <= '0;
			out_idx_q   <= '0;
			bitcnt_q    <= '0;
			len_q       <= '0;
			fin_q       <= 1'b0;
			pad_first_q <= 1'b0;
			len_ph_q    <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (byte_vld) begin
				fill_q <= fill_q + 6'd1;
			end
			if (absorb) begin
				bitcnt_q <= bitcnt_q + BYTE_BITS;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (finish) begin
				len_q       <= bitcnt_q;
				fin_q       <= 1'b1;
				pad_first_q <= 1'b1;
				len_ph_q    <= 1'b0;
				done_q      <= 1'b0;
			end
			if (state_q == ST_PAD) begin
				pad_first_q <= 1'b0;
				if (is_len) begin
					len_q    <= {len_q[55:0], 8'h00};
					len_ph_q <= 1'b1;
				end
				if (fill_q == BLOCK_LAST) begin
					done_q <= is_len;
				end
			end
			if (out_fire) begin
				out_idx_q <= out_idx_q + 3'd1;
			end
			if (out_last) begin
				bitcnt_q <= '0;
				fill_q   <= '0;
				fin_q    <= 1'b0;
				done_q   <= 1'b0;
				len_ph_q <= 1'b0;
			end
		end
	end

	`SHA_SH_ASSERT_NEXT(a_rounds_end_in_fold, clk, arst_n, state_q == ST_ROUND && rnd_q == BLOCK_LAST, state_q == ST_FOLD, "round count did not end in fold")
	`SHA_SH_ASSERT_NOW(a_out_only_when_done, clk, arst_n, state_q == ST_OUT, fin_q && done_q && fill_q == 6'd0, "digest shown before final block")
	`SHA_SH_ASSERT_NEXT(a_len_block_sets_done, clk, arst_n, state_q == ST_PAD && fill_q == BLOCK_LAST && is_len, done_q && state_q == ST_ROUND, "length block did not mark done")
	`SHA_SH_ASSERT_NOW(a_pad_only_in_finish, clk, arst_n, state_q == ST_PAD, fin_q && !done_q, "padding outside finish")

endmodule

`default_nettype wire
